>>> hw/rtl/sawa_pkg.sv
// Shared types and constants for the stop-and-wait ARQ endpoint.
// Item structs, result kinds, input modes and register indexes.
// No dependencies.
`default_nettype none

package sawa_pkg;

  // Default sizing
  localparam int SEQ_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int SEQ_OUT_W  = 32;
  localparam int PORT_W     = 16;
  localparam int LEN_W      = 16;
  localparam int MAXS_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MAXS_W-1:0] MAX_SENDS_RST = MAXS_W'(200);

  // Input modes
  localparam logic [1:0] MODE_SEND    = 2'd0;
  localparam logic [1:0] MODE_PKT     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;
  localparam logic [1:0] MODE_PDU     = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_TX_DATA   = 3'd0;
  localparam logic [2:0] KIND_TX_ACK    = 3'd1;
  localparam logic [2:0] KIND_DELIVER   = 3'd2;
  localparam logic [2:0] KIND_SEND_DONE = 3'd3;
  localparam logic [2:0] KIND_SEND_FAIL = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONN_OPEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PORT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_PORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SENDS   = 2'd3;

  typedef struct packed {
    logic [1:0]           mode;
    logic [SEQ_OUT_W-1:0] pkt_seq;
    logic [SEQ_OUT_W-1:0] pkt_ack_num;
    logic                 pkt_ack_flag;
    logic [PORT_W-1:0]    peer_port;
    logic [LEN_W-1:0]     payload_ref;
    logic [LEN_W-1:0]     payload_len;
  } sawa_cmd_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [SEQ_OUT_W-1:0] seq_out;
    logic [SEQ_OUT_W-1:0] ack_num_out;
    logic                 ack_flag_out;
    logic [PORT_W-1:0]    src_port_out;
    logic [PORT_W-1:0]    dst_port_out;
    logic [LEN_W-1:0]     buffer_ref_out;
    logic [LEN_W-1:0]     length_out;
    logic                 last;
  } sawa_rsp_t;

  // Work descriptor passed from front to back: first result, plus an
  // optional delivery result that follows it.
  typedef struct packed {
    sawa_rsp_t         first;
    logic              second;
    logic [LEN_W-1:0]  dref;
    logic [LEN_W-1:0]  dlen;
  } sawa_desc_t;

endpackage

`default_nettype wire

>>> hw/rtl/sawa_fifo.sv
// Short descriptor queue between the front and back parts.
// Depends on sawa_pkg for the descriptor type.
`default_nettype none

module sawa_fifo #(
  parameter int DEPTH = sawa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr_en,
  input  sawa_pkg::sawa_desc_t wr_data,
  output logic                 full,
  input  wire                  rd_en,
  output sawa_pkg::sawa_desc_t rd_data,
  output logic                 empty
);
  import sawa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  sawa_desc_t     slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // Fill level never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill level beyond depth");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sawa_front.sv
// Front part: configuration registers, ARQ protocol state and result
// formatting; pushes at most one descriptor per item. Depends on sawa_pkg.
`default_nettype none

module sawa_front #(
  parameter int SEQ_WIDTH   = sawa_pkg::SEQ_WIDTH_DEF,
  parameter int COUNT_WIDTH = sawa_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire  [sawa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [sawa_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire                                    accept,
  input  sawa_pkg::sawa_cmd_t                    cmd,
  output logic                                   q_push,
  output sawa_pkg::sawa_desc_t                   q_desc
);
  import sawa_pkg::*;

  localparam int CMP_W = ((COUNT_WIDTH > MAXS_W) ? COUNT_WIDTH : MAXS_W) + 1;

  // Configuration
  logic               connection_open;
  logic [PORT_W-1:0]  local_port;
  logic [PORT_W-1:0]  remote_port;
  logic [MAXS_W-1:0]  max_sends;

  // Protocol state
  logic [SEQ_WIDTH-1:0]   send_seq;
  logic [SEQ_WIDTH-1:0]   recv_expected;
  logic                   awaiting_ack;
  logic [COUNT_WIDTH-1:0] copies_sent;
  logic [LEN_W-1:0]       held_ref;
  logic [LEN_W-1:0]       held_len;

  logic [SEQ_WIDTH-1:0]   send_seq_next;
  logic [SEQ_WIDTH-1:0]   recv_expected_next;
  logic                   awaiting_ack_next;
  logic [COUNT_WIDTH-1:0] copies_sent_next;
  logic                   hold_load;

  logic [SEQ_OUT_W-1:0]   seq_view;
  logic [SEQ_WIDTH-1:0]   pseq_view;
  logic                   in_order;
  logic                   ack_match;
  logic                   may_resend;
  sawa_desc_t             desc;
  logic                   emit;

  // Sequence number views across the fixed 32-bit fields
  if (SEQ_WIDTH >= SEQ_OUT_W) begin : g_wide
    assign seq_view = send_seq[SEQ_OUT_W-1:0];
  end else begin : g_narrow
    assign seq_view = {{(SEQ_OUT_W-SEQ_WIDTH){1'b0}}, send_seq};
  end
  if (SEQ_WIDTH > SEQ_OUT_W) begin : g_pwide
    assign pseq_view = {{(SEQ_WIDTH-SEQ_OUT_W){1'b0}}, cmd.pkt_seq};
  end else begin : g_pnarrow
    assign pseq_view = cmd.pkt_seq[SEQ_WIDTH-1:0];
  end

  assign in_order   = (pseq_view == recv_expected);
  assign ack_match  = (cmd.mode == MODE_PKT) && cmd.pkt_ack_flag &&
                      (cmd.pkt_ack_num == seq_view);
  // copies + 1 < max_sends, i.e. copies below max_sends - 1
  assign may_resend = (CMP_W'(copies_sent) + CMP_W'(1)) < CMP_W'(max_sends);

  // Classify the item, compute state updates and the descriptor
  always_comb begin
    send_seq_next      = send_seq;
    recv_expected_next = recv_expected;
    awaiting_ack_next  = awaiting_ack;
    copies_sent_next   = copies_sent;
    hold_load          = 1'b0;
    emit               = 1'b1;
    desc               = '0;
    desc.first.last    = 1'b1;
    case (cmd.mode)
      MODE_SEND: begin
        if (!connection_open || awaiting_ack) begin
          desc.first.kind = KIND_SEND_FAIL;
        end else begin
          hold_load                  = 1'b1;
          awaiting_ack_next          = 1'b1;
          copies_sent_next           = COUNT_WIDTH'(1);
          desc.first.kind            = KIND_TX_DATA;
          desc.first.seq_out         = seq_view;
          desc.first.src_port_out    = local_port;
          desc.first.dst_port_out    = remote_port;
          desc.first.buffer_ref_out  = cmd.payload_ref;
          desc.first.length_out      = cmd.payload_len;
        end
      end
      MODE_PDU: begin
        desc.first.kind         = KIND_TX_ACK;
        desc.first.ack_num_out  = cmd.pkt_seq;
        desc.first.ack_flag_out = 1'b1;
        desc.first.src_port_out = local_port;
        desc.first.dst_port_out = cmd.peer_port;
        desc.first.last         = !in_order;
        desc.second             = in_order;
        desc.dref               = cmd.payload_ref;
        desc.dlen               = cmd.payload_len;
        if (in_order) begin
          recv_expected_next = recv_expected + SEQ_WIDTH'(1);
        end
      end
      default: begin
        // packet while waiting, or timeout
        if (!awaiting_ack) begin
          emit = 1'b0;
        end else if (ack_match) begin
          awaiting_ack_next     = 1'b0;
          send_seq_next         = send_seq + SEQ_WIDTH'(1);
          desc.first.kind       = KIND_SEND_DONE;
          desc.first.length_out = held_len;
        end else if (may_resend) begin
          copies_sent_next           = copies_sent + COUNT_WIDTH'(1);
          desc.first.kind            = KIND_TX_DATA;
          desc.first.seq_out         = seq_view;
          desc.first.src_port_out    = local_port;
          desc.first.dst_port_out    = remote_port;
          desc.first.buffer_ref_out  = held_ref;
          desc.first.length_out      = held_len;
        end else begin
          awaiting_ack_next = 1'b0;
          desc.first.kind   = KIND_SEND_FAIL;
        end
      end
    endcase
  end

  assign q_push = accept && emit;
  assign q_desc = desc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      connection_open <= 1'b0;
      local_port      <= '0;
      remote_port     <= '0;
      max_sends       <= MAX_SENDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONN_OPEN:   connection_open <= cfg_data[0];
        REG_LOCAL_PORT:  local_port      <= cfg_data[PORT_W-1:0];
        REG_REMOTE_PORT: remote_port     <= cfg_data[PORT_W-1:0];
        REG_MAX_SENDS:   max_sends       <= cfg_data[MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  // Protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      send_seq      <= '0;
      recv_expected <= '0;
      awaiting_ack  <= 1'b0;
      copies_sent   <= '0;
    end else if (accept) begin
      send_seq      <= send_seq_next;
      recv_expected <= recv_expected_next;
      awaiting_ack  <= awaiting_ack_next;
      copies_sent   <= copies_sent_next;
    end
  end

  // Held send payload, no reset
  always_ff @(posedge clk) begin
    if (accept && hold_load) begin
      held_ref <= cmd.payload_ref;
      held_len <= cmd.payload_len;
    end
  end

`ifndef SYNTHESIS
  // A pending send ends only on a packet or timeout item
  a_send_end: assert property (@(posedge clk) disable iff (rst)
    $fell(awaiting_ack) |->
      $past(accept && (cmd.mode == MODE_PKT || cmd.mode == MODE_TIMEOUT)))
    else $error("send ended without packet or timeout");

  // The send sequence advances only out of a pending send
  a_seq_adv: assert property (@(posedge clk) disable iff (rst)
    !$stable(send_seq) |-> ($past(awaiting_ack) && !awaiting_ack))
    else $error("send sequence moved outside a completed send");

  // A new send only starts from idle and connected
  a_send_start: assert property (@(posedge clk) disable iff (rst)
    $rose(awaiting_ack) |-> ($past(connection_open) && copies_sent == COUNT_WIDTH'(1)))
    else $error("send started while closed or with bad copy count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sawa_back.sv
// Back part: takes descriptors from the queue and presents one or two
// results each on the output queue interface. Depends on sawa_pkg.
`default_nettype none

module sawa_back (
  input  wire                  clk,
  input  wire                  rst,
  input  sawa_pkg::sawa_desc_t q_desc,
  input  wire                  q_empty,
  output logic                 q_pop,
  output logic                 empty,
  input  wire                  pop,
  output sawa_pkg::sawa_rsp_t  rsp
);
  import sawa_pkg::*;

  sawa_desc_t cur;
  logic       cur_valid;
  logic       phase;
  logic       taken;
  logic       finishing;
  sawa_rsp_t  deliver;

  assign taken     = pop && cur_valid;
  assign finishing = phase || !cur.second;
  assign q_pop     = !q_empty && (!cur_valid || (taken && finishing));
  assign empty     = !cur_valid;

  // Delivery result built from the held descriptor
  always_comb begin
    deliver                = '0;
    deliver.kind           = KIND_DELIVER;
    deliver.buffer_ref_out = cur.dref;
    deliver.length_out     = cur.dlen;
    deliver.last           = 1'b1;
  end

  assign rsp = phase ? deliver : cur.first;

  // Current descriptor and result phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (taken && !finishing) begin
      phase <= 1'b1;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (taken) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_desc;
    end
  end

`ifndef SYNTHESIS
  // Second phase only follows an in-order ack
  a_phase: assert property (@(posedge clk) disable iff (rst)
    phase |-> (cur_valid && cur.second && cur.first.kind == KIND_TX_ACK))
    else $error("delivery phase without an in-order ack");

  // An unfinished two-result descriptor is not replaced
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !phase && cur.second && !pop) |=> (cur_valid && !phase && $stable(cur)))
    else $error("descriptor lost before both results went out");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/stop_and_wait_arq_endpoint_unit.sv
// Stop-and-wait ARQ endpoint, top level.
// Depends on sawa_pkg, sawa_front, sawa_fifo and sawa_back.
//
// Use: input items (send request, packet while waiting, timeout, data PDU)
// go in on cmd with push/full; an item is taken when push is high and full
// is low. Results come out on rsp with empty/pop, oldest first; one is taken
// when pop is high and empty is low. rsp.last marks the final result of an
// item. Registers are written through cfg_we/cfg_index/cfg_data while idle.
// An accepted item's descriptor is written into the queue at the accepting
// edge and then loaded into the back register, where its first result shows.
// Items are taken at one per cycle while full is low; an in-order data PDU
// makes two results and holds the back register for two pops, so a stream
// of those is limited by the single result port.
// A packet or timeout while no send is pending gives no result.
// Reset clears all control state and the queues; registers take their reset
// values (max_sends 200). No clearing pass is needed. When the receiver
// stalls, the back register holds its result, the descriptor queue fills,
// and full rises; items already accepted are never lost.
`default_nettype none

module stop_and_wait_arq_endpoint_unit #(
  parameter int SEQ_WIDTH   = sawa_pkg::SEQ_WIDTH_DEF,
  parameter int COUNT_WIDTH = sawa_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = sawa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [sawa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [sawa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                              push,
  output logic                             full,
  input  sawa_pkg::sawa_cmd_t              cmd,
  output logic                             empty,
  input  wire                              pop,
  output sawa_pkg::sawa_rsp_t              rsp
);
  import sawa_pkg::*;

  logic       accept;
  logic       q_push;
  sawa_desc_t q_wdata;
  sawa_desc_t q_rdata;
  logic       q_pop;
  logic       q_empty;

  assign accept = push && !full;

  // Protocol front
  sawa_front #(
    .SEQ_WIDTH   (SEQ_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .q_push    (q_push),
    .q_desc    (q_wdata)
  );

  // Descriptor queue
  sawa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Result back end
  sawa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_desc  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp)
  );

`ifndef SYNTHESIS
  // Every result is announced as the last one or followed by a delivery
  a_last_or_ack: assert property (@(posedge clk) disable iff (rst)
    (!empty && !rsp.last) |-> (rsp.kind == KIND_TX_ACK))
    else $error("non-final result that is not an ack");

  // A taken non-final ack is followed by its delivery result
  a_deliver_next: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !rsp.last) |=> (!empty && rsp.kind == KIND_DELIVER && rsp.last))
    else $error("delivery did not follow an in-order ack");
`endif

endmodule

`default_nettype wire

>>> test/tb_stop_and_wait_arq_endpoint_unit.sv
// Self-checking testbench for the stop-and-wait ARQ endpoint unit.
// Predicts every result item from its own model of the endpoint and checks them in order.
// Depends on sawa_pkg and stop_and_wait_arq_endpoint_unit.
`timescale 1ns / 100ps

module tb_stop_and_wait_arq_endpoint_unit;
  import sawa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  sawa_cmd_t cmd = '0;
  logic empty;
  logic pop = 1'b0;
  sawa_rsp_t rsp;

  // Predicted register and protocol state
  logic link_open = 1'b0;
  logic [PORT_W-1:0] port_local = '0;
  logic [PORT_W-1:0] port_remote = '0;
  logic [MAXS_W-1:0] tx_limit = MAX_SENDS_RST;
  logic [31:0] next_tx_seq = '0;
  logic [31:0] rx_next_seq = '0;
  logic ack_pending = 1'b0;
  logic [MAXS_W-1:0] tx_count = '0;
  logic [LEN_W-1:0] pend_bref = '0;
  logic [LEN_W-1:0] pend_blen = '0;

  sawa_rsp_t due_results[$];
  int errors = 0;
  int answered_items = 0;
  int cycle_count = 0;
  int hold_req = 0;
  bit quiet = 1'b0;
  bit sender_gaps = 1'b1;

  stop_and_wait_arq_endpoint_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .cmd(cmd),
    .empty(empty),
    .pop(pop),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic sawa_rsp_t make_result(logic [2:0] kind, logic [31:0] seq,
                                            logic [31:0] ackn, logic ackf,
                                            logic [PORT_W-1:0] src, logic [PORT_W-1:0] dst,
                                            logic [LEN_W-1:0] bref, logic [LEN_W-1:0] blen,
                                            logic lst);
    sawa_rsp_t r;
    r.kind = kind;
    r.seq_out = seq;
    r.ack_num_out = ackn;
    r.ack_flag_out = ackf;
    r.src_port_out = src;
    r.dst_port_out = dst;
    r.buffer_ref_out = bref;
    r.length_out = blen;
    r.last = lst;
    return r;
  endfunction

  // Endpoint behaviour for one accepted item; queues the results it causes
  task automatic predict_endpoint_results(input sawa_cmd_t c);
    logic in_order;
    int queued_at_start;
    queued_at_start = due_results.size();
    case (c.mode)
      MODE_SEND: begin
        if (!link_open || ack_pending) begin
          due_results.push_back(make_result(KIND_SEND_FAIL, '0, '0, 1'b0, '0, '0, '0, '0,
                                            1'b1));
        end else begin
          pend_bref = c.payload_ref;
          pend_blen = c.payload_len;
          ack_pending = 1'b1;
          tx_count = MAXS_W'(1);
          due_results.push_back(make_result(KIND_TX_DATA, next_tx_seq, '0, 1'b0, port_local,
                                            port_remote, pend_bref, pend_blen, 1'b1));
        end
      end
      MODE_PDU: begin
        in_order = (c.pkt_seq == rx_next_seq);
        due_results.push_back(make_result(KIND_TX_ACK, '0, c.pkt_seq, 1'b1, port_local,
                                          c.peer_port, '0, '0, !in_order));
        if (in_order) begin
          due_results.push_back(make_result(KIND_DELIVER, '0, '0, 1'b0, '0, '0, c.payload_ref,
                                            c.payload_len, 1'b1));
          rx_next_seq = rx_next_seq + 32'd1;
        end
      end
      default: begin
        // packet or timeout: only matters while a send is outstanding
        if (ack_pending) begin
          if (c.mode == MODE_PKT && c.pkt_ack_flag && c.pkt_ack_num == next_tx_seq) begin
            ack_pending = 1'b0;
            next_tx_seq = next_tx_seq + 32'd1;
            due_results.push_back(make_result(KIND_SEND_DONE, '0, '0, 1'b0, '0, '0, '0,
                                              pend_blen, 1'b1));
          end else if (int'(tx_count) < int'(tx_limit) - 1) begin
            tx_count = tx_count + MAXS_W'(1);
            due_results.push_back(make_result(KIND_TX_DATA, next_tx_seq, '0, 1'b0, port_local,
                                              port_remote, pend_bref, pend_blen, 1'b1));
          end else begin
            ack_pending = 1'b0;
            due_results.push_back(make_result(KIND_SEND_FAIL, '0, '0, 1'b0, '0, '0, '0, '0,
                                              1'b1));
          end
        end
      end
    endcase
    if (due_results.size() != queued_at_start) answered_items++;
  endtask

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endfunction

  // Result checker: compare each popped item with the oldest prediction
  always @(posedge clk) begin
    sawa_rsp_t exp;
    if (!rst && pop && !empty) begin
      if (due_results.size() == 0) begin
        $error("result with none expected: kind %0d", rsp.kind);
        errors++;
      end else begin
        exp = due_results.pop_front();
        check_field("kind", 32'(exp.kind), 32'(rsp.kind));
        check_field("seq_out", exp.seq_out, rsp.seq_out);
        check_field("ack_num_out", exp.ack_num_out, rsp.ack_num_out);
        check_field("ack_flag_out", 32'(exp.ack_flag_out), 32'(rsp.ack_flag_out));
        check_field("src_port_out", 32'(exp.src_port_out), 32'(rsp.src_port_out));
        check_field("dst_port_out", 32'(exp.dst_port_out), 32'(rsp.dst_port_out));
        check_field("buffer_ref_out", 32'(exp.buffer_ref_out), 32'(rsp.buffer_ref_out));
        check_field("length_out", 32'(exp.length_out), 32'(rsp.length_out));
        check_field("last", 32'(exp.last), 32'(rsp.last));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int stall;
    int hold;
    int seen;
    stall = 0;
    hold = 0;
    seen = 0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 13);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic sawa_cmd_t rand_cmd(logic [1:0] m);
    sawa_cmd_t c;
    c.mode = m;
    c.pkt_seq = $urandom;
    c.pkt_ack_num = $urandom;
    c.pkt_ack_flag = 1'($urandom_range(0, 1));
    c.peer_port = PORT_W'($urandom_range(0, 65535));
    c.payload_ref = LEN_W'($urandom_range(0, 65535));
    c.payload_len = LEN_W'($urandom_range(0, 65535));
    return c;
  endfunction

  // Offer one item; called just after a falling edge, returns on one.
  // push is left high unless a gap follows, so back-to-back items need no re-raise.
  task automatic send_item(input sawa_cmd_t c);
    int gap;
    cmd <= c;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_endpoint_results(c);
    @(negedge clk);
    if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering, wait for every predicted result, then let the pipe settle
  task automatic wait_idle();
    push <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CONN_OPEN: link_open = data[0];
      REG_LOCAL_PORT: port_local = data;
      REG_REMOTE_PORT: port_remote = data;
      REG_MAX_SENDS: tx_limit = data[MAXS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Data PDU, mostly in order, otherwise a near miss or a random number
  task automatic send_pdu();
    sawa_cmd_t c;
    c = rand_cmd(MODE_PDU);
    case ($urandom_range(0, 9))
      0: c.pkt_seq = rx_next_seq + 32'd1;
      1: c.pkt_seq = rx_next_seq - 32'd1;
      2: ;
      default: c.pkt_seq = rx_next_seq;
    endcase
    send_item(c);
  endtask

  // One send: request, a few misses of assorted sorts, usually the matching ack
  task automatic send_exchange();
    sawa_cmd_t c;
    int misses;
    send_item(rand_cmd(MODE_SEND));
    misses = $urandom_range(0, 3);
    repeat (misses) begin
      case ($urandom_range(0, 5))
        0: c = rand_cmd(MODE_TIMEOUT);
        1: begin
          c = rand_cmd(MODE_PKT);
          c.pkt_ack_flag = 1'b0;
          c.pkt_ack_num = next_tx_seq;
        end
        2: begin
          c = rand_cmd(MODE_PKT);
          c.pkt_ack_flag = 1'b1;
          c.pkt_ack_num = next_tx_seq + 32'($urandom_range(1, 3));
        end
        3: c = rand_cmd(MODE_PKT);
        4: c = rand_cmd(MODE_SEND);
        default: begin
          c = rand_cmd(MODE_PDU);
          c.pkt_seq = rx_next_seq;
        end
      endcase
      send_item(c);
    end
    if ($urandom_range(0, 4) != 0) begin
      c = rand_cmd(MODE_PKT);
      c.pkt_ack_flag = 1'b1;
      c.pkt_ack_num = next_tx_seq;
      send_item(c);
    end
  endtask

  // Reset values: connection closed, ports zero
  task automatic test_closed_defaults();
    sawa_cmd_t c;
    c = rand_cmd(MODE_SEND);
    c.payload_ref = '1;
    c.payload_len = '1;
    send_item(c);
    send_item(rand_cmd(MODE_TIMEOUT));
    c = rand_cmd(MODE_PKT);
    c.pkt_ack_flag = 1'b1;
    c.pkt_ack_num = '0;
    send_item(c);
    // data PDUs are taken even while closed
    c = rand_cmd(MODE_PDU);
    c.pkt_seq = '0;
    c.peer_port = '1;
    c.payload_ref = '1;
    c.payload_len = '1;
    send_item(c);
    c = rand_cmd(MODE_PDU);
    c.pkt_seq = '1;
    c.peer_port = '0;
    c.payload_ref = '0;
    c.payload_len = '0;
    send_item(c);
    wait_idle();
  endtask

  // Retransmission, busy sends, the send limit at several settings
  task automatic test_send_and_retry();
    sawa_cmd_t c;
    write_reg(REG_CONN_OPEN, 16'h0001);
    write_reg(REG_LOCAL_PORT, 16'hFFFF);
    write_reg(REG_REMOTE_PORT, 16'h0000);
    write_reg(REG_MAX_SENDS, 16'd3);
    c = rand_cmd(MODE_SEND);
    c.payload_ref = '0;
    c.payload_len = '0;
    send_item(c);
    send_item(rand_cmd(MODE_SEND));
    send_item(rand_cmd(MODE_TIMEOUT));
    c = rand_cmd(MODE_PKT);
    c.pkt_ack_flag = 1'b1;
    c.pkt_ack_num = next_tx_seq - 32'd1;
    send_item(c);
    c = rand_cmd(MODE_SEND);
    c.payload_ref = 16'h1234;
    c.payload_len = 16'hABCD;
    send_item(c);
    c = rand_cmd(MODE_PKT);
    c.pkt_ack_flag = 1'b0;
    c.pkt_ack_num = next_tx_seq;
    send_item(c);
    c.pkt_ack_flag = 1'b1;
    send_item(c);
    wait_idle();

    // limit of zero: the first miss fails
    write_reg(REG_MAX_SENDS, 16'd0);
    write_reg(REG_LOCAL_PORT, 16'h0000);
    write_reg(REG_REMOTE_PORT, 16'hFFFF);
    send_item(rand_cmd(MODE_SEND));
    send_item(rand_cmd(MODE_TIMEOUT));
    wait_idle();

    // limit of one behaves the same
    write_reg(REG_MAX_SENDS, 16'd1);
    send_item(rand_cmd(MODE_SEND));
    c = rand_cmd(MODE_PKT);
    c.pkt_ack_flag = 1'b1;
    c.pkt_ack_num = next_tx_seq + 32'd1;
    send_item(c);
    wait_idle();

    // top limit, upper data bits set on every write
    write_reg(REG_MAX_SENDS, 16'hFFFF);
    write_reg(REG_CONN_OPEN, 16'hFFFF);
    send_item(rand_cmd(MODE_SEND));
    repeat (3) send_item(rand_cmd(MODE_TIMEOUT));
    c = rand_cmd(MODE_PDU);
    c.pkt_seq = rx_next_seq;
    send_item(c);
    c = rand_cmd(MODE_PKT);
    c.pkt_ack_flag = 1'b1;
    c.pkt_ack_num = next_tx_seq;
    send_item(c);
    // duplicate PDU: acked, not delivered
    c = rand_cmd(MODE_PDU);
    c.pkt_seq = rx_next_seq - 32'd1;
    send_item(c);
    wait_idle();

    write_reg(REG_CONN_OPEN, 16'hFFFE);
    send_item(rand_cmd(MODE_SEND));
    c = rand_cmd(MODE_PDU);
    c.pkt_seq = rx_next_seq;
    send_item(c);
    wait_idle();
    write_reg(REG_CONN_OPEN, 16'h0001);
  endtask

  // Receiver holds off while the sender streams, so the block fills and stalls
  task automatic test_full_stall();
    sawa_cmd_t c;
    hold_req++;
    sender_gaps = 1'b0;
    repeat (24) begin
      c = rand_cmd(MODE_PDU);
      c.pkt_seq = rx_next_seq;
      send_item(c);
    end
    sender_gaps = 1'b1;
    wait_idle();
  endtask

  // Random traffic in rounds, with a fresh register setting between rounds
  task automatic test_random_traffic(input int target);
    int start;
    int round_items;
    int pick;
    logic [CFG_DATA_W-1:0] d;
    start = answered_items;
    round_items = 0;
    while (answered_items - start < target) begin
      if (round_items >= 40) begin
        wait_idle();
        d = CFG_DATA_W'($urandom);
        d[0] = ($urandom_range(0, 9) != 0);
        write_reg(REG_CONN_OPEN, d);
        write_reg(REG_LOCAL_PORT, CFG_DATA_W'($urandom));
        write_reg(REG_REMOTE_PORT, CFG_DATA_W'($urandom));
        d = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 9))
          0: d[MAXS_W-1:0] = '0;
          1: d[MAXS_W-1:0] = MAXS_W'(1);
          2: d[MAXS_W-1:0] = MAXS_W'(1023);
          3: d[MAXS_W-1:0] = MAXS_W'(2);
          default: d[MAXS_W-1:0] = MAXS_W'($urandom_range(3, 6));
        endcase
        write_reg(REG_MAX_SENDS, d);
        round_items = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) send_exchange();
      else if (pick < 75) send_pdu();
      else send_item(rand_cmd(2'($urandom_range(0, 3))));
      round_items++;
    end
    wait_idle();
  endtask

  // Closing stretch: both sides run flat out
  task automatic test_unstalled_stream(input int target);
    int start;
    start = answered_items;
    quiet = 1'b1;
    while (answered_items - start < target) begin
      if ($urandom_range(0, 1) == 0) send_exchange();
      else send_pdu();
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_closed_defaults();
    test_send_and_retry();
    test_full_stall();
    test_random_traffic(430);
    test_unstalled_stream(60);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sawa_pkg.sv
hw/rtl/sawa_fifo.sv
hw/rtl/sawa_front.sv
hw/rtl/sawa_back.sv
hw/rtl/stop_and_wait_arq_endpoint_unit.sv
test/tb_stop_and_wait_arq_endpoint_unit.sv
